// ----- rtl/core/msc_pkg.sv -----
// Shared types and constants of the masked byte pattern scanner.
package msc_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam int SLOT_W  = 5;
  localparam int PLEN_W  = 6;
  localparam int ADD_W   = 5;
  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 128;
  localparam int CFG_I_W = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_MATCH   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [CFG_I_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_I_W-1:0] CFG_PLEN = 2'd1;
  localparam logic [CFG_I_W-1:0] CFG_ADD  = 2'd2;
  localparam logic [CFG_I_W-1:0] CFG_RIP  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [PLEN_W-1:0] pattern_length;
    logic [ADD_W-1:0]  add_offset;
    logic              rip_mode;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] pattern_slot;
    logic [7:0]        pattern_value;
    logic              pattern_wild;
    logic [7:0]        image_byte;
    logic              last_byte;
  } item_t;

  // Result of the compare stage, handed to the address stage.
  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [CNT_W-1:0] start;
    logic [33:0]      term;
    logic [31:0]      disp;
    logic [CNT_W-1:0] count;
  } hit_t;

endpackage

// ----- rtl/core/masked_byte_pattern_scan_top.sv -----
// A result word goes through the input register, the compare register and the output register.
// Throughput: one word per cycle; the whole pipeline holds only while the output
// word waits, so tready follows the output register.
// Reset (rst, synchronous): window, byte position, found flag and counter clear;
// registers go to base 0, length 1, offset 0, rip mode off. Pattern is unset.
module masked_byte_pattern_scan_top import msc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  // pattern_slot[4:0], pattern_value[12:5], pattern_wild[13], image_byte[21:14], zero pad
  input  logic [IN_W-1:0]    s_tdata,
  // operation[0]
  input  logic               s_tuser,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // found_address[63:0], match_offset[95:64], scans_found[127:96]
  output logic [OUT_W-1:0]   m_tdata,
  // status[1:0]
  output logic [1:0]         m_tuser
);

  cfg_t  cfg;
  item_t item;
  item_t item_in;
  logic  in_valid;
  logic  adv;
  hit_t  res;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address   <= '0;
      cfg.pattern_length <= PLEN_W'(1);
      cfg.add_offset     <= '0;
      cfg.rip_mode       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE: cfg.base_address   <= cfg_data;
        CFG_PLEN: cfg.pattern_length <= cfg_data[PLEN_W-1:0];
        CFG_ADD:  cfg.add_offset     <= cfg_data[ADD_W-1:0];
        CFG_RIP:  cfg.rip_mode       <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    item_in.operation     = s_tuser;
    item_in.pattern_slot  = s_tdata[4:0];
    item_in.pattern_value = s_tdata[12:5];
    item_in.pattern_wild  = s_tdata[13];
    item_in.image_byte    = s_tdata[21:14];
    item_in.last_byte     = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      item <= item_in;
    end
  end

  msc_match u_match (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .item     (item),
    .cfg      (cfg),
    .res      (res)
  );

  msc_addr u_addr (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .res          (res),
    .base_address (cfg.base_address),
    .out_valid    (m_tvalid),
    .status       (m_tuser),
    .out_data     (m_tdata)
  );

endmodule

// ----- rtl/core/msc_match.sv -----
// Pattern store, byte window and parallel masked compare stage.
module msc_match import msc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  item_t item,
  input  cfg_t  cfg,
  output hit_t  res
);

  logic [7:0]       pat   [PATTERN_MAX];
  logic             wild  [PATTERN_MAX];
  logic [7:0]       win   [PATTERN_MAX];
  logic [7:0]       win_next [PATTERN_MAX];
  logic [IDX_W-1:0] win_idx  [PATTERN_MAX];
  logic [CNT_W-1:0] pos;
  logic             found;
  logic [CNT_W-1:0] count;

  logic [LEN_W-1:0] len_eff;
  logic             enough;
  logic             all_ok;
  logic             hit;
  logic             fire_scan;
  logic             disp_ok;
  logic             use_disp;
  logic [7:0]       at;
  logic [31:0]      disp;
  logic [CNT_W-1:0] start;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg.pattern_length) > 32'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(cfg.pattern_length);
    end
  end

  // Newest byte sits at index 0.
  always_comb begin
    win_next[0] = item.image_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_next[k] = win[k-1];
    end
  end

  // Pattern entry i lines up with the window byte len-1-i.
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_idx[i] = IDX_W'(len_eff - LEN_W'(1) - LEN_W'(i));
      if (LEN_W'(i) < len_eff && !wild[i] && pat[i] != win_next[win_idx[i]]) begin
        all_ok = 1'b0;
      end
    end
  end

  always_comb begin
    fire_scan  = adv && in_valid && item.operation == OP_SCAN;
    enough     = pos >= (32'(len_eff) - 32'd1);
    hit        = fire_scan && !found && enough && all_ok;
    start      = pos - (32'(len_eff) - 32'd1);
    disp_ok    = (8'(cfg.add_offset) + 8'd4) <= 8'(len_eff);
    use_disp   = cfg.rip_mode && disp_ok;
    at         = 8'(len_eff) - 8'd1 - 8'(cfg.add_offset);
    disp       = {win_next[IDX_W'(at - 8'd3)], win_next[IDX_W'(at - 8'd2)],
                  win_next[IDX_W'(at - 8'd1)], win_next[IDX_W'(at)]};
    count_next = count + CNT_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid && item.operation == OP_LOAD
        && 32'(item.pattern_slot) < 32'(PATTERN_MAX)) begin
      pat[IDX_W'(item.pattern_slot)]  <= item.pattern_value;
      wild[IDX_W'(item.pattern_slot)] <= item.pattern_wild;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win[k] <= '0;
      end
      pos   <= '0;
      found <= 1'b0;
      count <= '0;
    end else if (fire_scan) begin
      count <= count_next;
      if (item.last_byte) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win[k] <= '0;
        end
        pos   <= '0;
        found <= 1'b0;
      end else begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win[k] <= win_next[k];
        end
        pos   <= pos + 32'd1;
        found <= found || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= hit || (fire_scan && item.last_byte && !found);
      res.count <= count_next;
      if (hit) begin
        res.status <= (cfg.rip_mode && !disp_ok) ? ST_OUTSIDE : ST_MATCH;
        res.start  <= start;
        res.term   <= 34'(start) + 34'(cfg.add_offset) + (use_disp ? 34'd4 : 34'd0);
        res.disp   <= use_disp ? disp : 32'd0;
      end else begin
        res.status <= ST_NONE;
        res.start  <= '0;
        res.term   <= '0;
        res.disp   <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_second_hit: assert property (@(posedge clk) disable iff (rst)
    found |-> !hit)
    else $error("second match reported within one scan");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire_scan && item.last_byte |=> pos == '0 && !found)
    else $error("scan state not cleared after last byte");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_NONE |-> res.start == '0 && res.disp == '0)
    else $error("no-match word carries match data");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire_scan |=> count == $past(count) + CNT_W'($past(hit)))
    else $error("found counter stepped wrongly");
`endif

endmodule

// ----- rtl/core/msc_addr.sv -----
// Address resolve stage and output word register.
module msc_addr import msc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  hit_t              res,
  input  logic [ADDR_W-1:0] base_address,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic [OUT_W-1:0]  out_data
);

  logic [ADDR_W-1:0] addr;

  always_comb begin
    if (res.status == ST_NONE) begin
      addr = '0;
    end else begin
      addr = base_address + ADDR_W'(res.term) + {{32{res.disp[31]}}, res.disp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status   <= res.status;
      out_data <= {res.count, res.start, addr};
    end
  end

endmodule

// ----- tb/masked_byte_pattern_scan_top_tb.sv -----
// Self-checking testbench for the masked byte pattern scanner top level.
module masked_byte_pattern_scan_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;
    logic [31:0]       offset;
    logic [CNT_W-1:0]  found;
  } scan_result_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [CFG_I_W-1:0] cfg_index = CFG_BASE;
  logic [ADDR_W-1:0]  cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata   = '0;
  logic               s_tuser   = 1'b0;
  logic               s_tlast   = 1'b0;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic [1:0]         m_tuser;

  masked_byte_pattern_scan_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scanner state as seen by the predictor.
  logic [ADDR_W-1:0] cfg_base = '0;
  logic [PLEN_W-1:0] cfg_plen = 6'd1;
  logic [ADD_W-1:0]  cfg_add  = '0;
  logic              cfg_rip  = 1'b0;
  logic [7:0]        pat_val  [PATTERN_MAX] = '{default: 8'h00};
  logic              pat_wild [PATTERN_MAX] = '{default: 1'b0};
  logic [7:0]        win      [PATTERN_MAX] = '{default: 8'h00};
  logic [31:0]       scan_pos    = '0;
  logic              scan_done   = 1'b0;
  logic [CNT_W-1:0]  found_total = '0;

  scan_result_t expected_results [$];

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 48;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned words_sent    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned errors        = 0;

  function automatic int unsigned active_len();
    if (cfg_plen == 0) return 1;
    if (cfg_plen > PATTERN_MAX) return PATTERN_MAX;
    return 32'(cfg_plen);
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < PATTERN_MAX; k++) win[k] = 8'h00;
    scan_pos  = '0;
    scan_done = 1'b0;
  endfunction

  // Works out the result word, if any, that one accepted input word causes.
  function automatic void predict_word(input item_t w);
    int unsigned  len;
    int unsigned  at;
    logic [31:0]  pos;
    logic [31:0]  disp;
    bit           hit;
    bit           had;
    scan_result_t res;
    if (w.operation == OP_LOAD) begin
      pat_val[w.pattern_slot]  = w.pattern_value;
      pat_wild[w.pattern_slot] = w.pattern_wild;
      return;
    end
    for (int k = PATTERN_MAX - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = w.image_byte;
    pos = scan_pos;
    scan_pos = pos + 32'd1;
    len = active_len();
    hit = 1'b0;
    if (!scan_done && ({32'd0, pos} + 64'd1 >= 64'(len))) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++)
        if (!pat_wild[i] && pat_val[i] != win[len-1-i]) hit = 1'b0;
    end
    if (hit) begin
      res.status  = ST_MATCH;
      res.offset  = pos - 32'(len - 1);
      res.address = cfg_base + 64'(res.offset) + 64'(cfg_add);
      if (cfg_rip) begin
        if (32'(cfg_add) + 32'd4 <= len) begin
          // The displacement is stored little-endian, oldest byte lowest.
          at = len - 1 - 32'(cfg_add);
          disp = {win[at-3], win[at-2], win[at-1], win[at]};
          res.address = res.address + {{32{disp[31]}}, disp} + 64'd4;
        end else begin
          res.status = ST_OUTSIDE;
        end
      end
      scan_done   = 1'b1;
      found_total = found_total + 32'd1;
      res.found   = found_total;
      expected_results.push_back(res);
      if (w.last_byte) clear_scan();
    end else if (w.last_byte) begin
      had = scan_done;
      clear_scan();
      if (!had) begin
        res.status  = ST_NONE;
        res.address = '0;
        res.offset  = '0;
        res.found   = found_total;
        expected_results.push_back(res);
      end
    end
  endfunction

  // Offers one word and returns at the edge where it is taken; tvalid stays high.
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.operation;
    s_tlast  <= w.last_byte;
    s_tdata  <= {2'b00, w.image_byte, w.pattern_wild, w.pattern_value, w.pattern_slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(w);
    words_sent++;
  endtask

  task automatic load_entry(input logic [SLOT_W-1:0] slot, input logic [7:0] value,
                            input logic wild);
    item_t w;
    w.operation     = OP_LOAD;
    w.pattern_slot  = slot;
    w.pattern_value = value;
    w.pattern_wild  = wild;
    w.image_byte    = 8'($urandom_range(255));
    w.last_byte     = 1'($urandom_range(1));
    send_word(w);
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    item_t w;
    w.operation     = OP_SCAN;
    w.pattern_slot  = SLOT_W'($urandom_range(31));
    w.pattern_value = 8'($urandom_range(255));
    w.pattern_wild  = 1'($urandom_range(1));
    w.image_byte    = b;
    w.last_byte     = last;
    send_word(w);
  endtask

  // Stops offering and waits until every result is in and the pipeline is empty.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] base, plen, add, rip);
    logic [63:0]        reg_value [4];
    logic [CFG_I_W-1:0] reg_index [4];
    reg_index[0] = CFG_BASE;
    reg_index[1] = CFG_PLEN;
    reg_index[2] = CFG_ADD;
    reg_index[3] = CFG_RIP;
    reg_value[0] = base;
    reg_value[1] = plen;
    reg_value[2] = add;
    reg_value[3] = rip;
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index[r];
      cfg_data  <= reg_value[r];
      @(posedge clk);
      case (reg_index[r])
        CFG_BASE: cfg_base = reg_value[r];
        CFG_PLEN: cfg_plen = reg_value[r][PLEN_W-1:0];
        CFG_ADD:  cfg_add  = reg_value[r][ADD_W-1:0];
        default:  cfg_rip  = reg_value[r][0];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // One-entry pattern at reset settings: match, bytes after it, a scan with no match.
  task automatic test_single_byte();
    load_entry(5'd0, 8'hAB, 1'b0);
    load_entry(5'd31, 8'hFF, 1'b1);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'hAB, 1'b1);
    scan_byte(8'hFF, 1'b1);
  endtask

  // Displacement resolved inside the window, then one that reaches past it.
  task automatic test_rip_displacement();
    wait_quiet();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd4, 64'd0, 64'd1);
    load_entry(5'd1, 8'h00, 1'b1);
    load_entry(5'd2, 8'h12, 1'b0);
    load_entry(5'd3, 8'hFF, 1'b0);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h55, 1'b0);
    scan_byte(8'h12, 1'b0);
    scan_byte(8'hFF, 1'b1);
    wait_quiet();
    set_config(64'h0000_0000_0000_1000, 64'd4, 64'd1, 64'd1);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h12, 1'b0);
    scan_byte(8'hFF, 1'b1);
    // A length of zero behaves as one entry.
    wait_quiet();
    set_config(64'd0, 64'd0, 64'd31, 64'd1);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'hAB, 1'b1);
  endtask

  // A scan that ends before the pattern fits, then a fresh scan that matches.
  task automatic test_short_scan();
    wait_quiet();
    set_config(64'd0, 64'd4, 64'd0, 64'd0);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h00, 1'b1);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h7E, 1'b0);
    scan_byte(8'h12, 1'b0);
    scan_byte(8'hFF, 1'b1);
  endtask

  // Every scan byte gives a result while the receiver holds off, so the block backs up.
  task automatic test_output_backpressure();
    int unsigned keep;
    wait_quiet();
    set_config(64'h8000_0000_0000_0000, 64'd1, 64'd3, 64'd0);
    keep = send_idle_pct;
    send_idle_pct = 0;
    load_entry(5'd0, 8'h00, 1'b1);
    hold_request = 300;
    repeat (60) scan_byte(8'($urandom_range(255)), 1'b1);
    send_idle_pct = keep;
  endtask

  task automatic random_config();
    logic [63:0] base;
    logic [63:0] plen;
    logic [63:0] add;
    logic [63:0] rip;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) base = '0;
    else if (pick < 20) base = '1;
    else base = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 55) plen = 64'($urandom_range(8, 1));
    else if (pick < 75) plen = 64'($urandom_range(31, 9));
    else if (pick < 85) plen = 64'd32;
    else if (pick < 90) plen = 64'd0;
    else plen = 64'($urandom_range(63, 33));
    pick = $urandom_range(99);
    if (pick < 15) add = 64'd0;
    else if (pick < 25) add = 64'd31;
    else add = 64'($urandom_range(31));
    rip = 64'($urandom_range(1));
    // Bits above a register's width must be dropped by the block.
    if ($urandom_range(3) == 0) begin
      plen = plen | ({$urandom, $urandom} << PLEN_W);
      add  = add  | ({$urandom, $urandom} << ADD_W);
      rip  = rip  | ({$urandom, $urandom} << 1);
    end
    set_config(base, plen, add, rip);
  endtask

  // A scan with random bytes around an optional copy of the current pattern.
  task automatic send_random_scan();
    logic [7:0]  bytes [$];
    int unsigned len;
    int unsigned spot;
    len = active_len();
    repeat ($urandom_range(6)) bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 75) begin
      for (int i = 0; i < len; i++)
        bytes.push_back(pat_wild[i] ? 8'($urandom_range(255)) : pat_val[i]);
      if ($urandom_range(99) < 15) begin
        spot = bytes.size() - len + $urandom_range(len - 1);
        bytes[spot] = bytes[spot] ^ (8'h01 << $urandom_range(7));
      end
    end
    repeat ($urandom_range(6)) bytes.push_back(8'($urandom_range(255)));
    if (bytes.size() == 0) bytes.push_back(8'($urandom_range(255)));
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(99) < 3)
        load_entry(SLOT_W'($urandom_range(31)), 8'($urandom_range(255)),
                   $urandom_range(99) < 25);
      scan_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = words_sent + n_words;
    for (int s = 0; s < PATTERN_MAX; s++)
      load_entry(SLOT_W'(s), 8'($urandom_range(255)), $urandom_range(99) < 25);
    while (words_sent < stop_at) begin
      wait_quiet();
      random_config();
      repeat ($urandom_range(4))
        load_entry(SLOT_W'($urandom_range(active_len() - 1)), 8'($urandom_range(255)),
                   $urandom_range(99) < 25);
      repeat ($urandom_range(8, 3)) send_random_scan();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d, data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, m_tuser);
          errors++;
        end
        if (m_tdata[63:0] !== want.address) begin
          $display("%0t: found_address expected %h, actual %h",
                   $time, want.address, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[95:64] !== want.offset) begin
          $display("%0t: match_offset expected %0d, actual %0d",
                   $time, want.offset, m_tdata[95:64]);
          errors++;
        end
        if (m_tdata[127:96] !== want.found) begin
          $display("%0t: scans_found expected %0d, actual %0d",
                   $time, want.found, m_tdata[127:96]);
          errors++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_byte();
    test_rip_displacement();
    test_short_scan();
    test_output_backpressure();
    test_random_traffic(400, 33, 48);
    test_random_traffic(400, 48, 33);
    test_random_traffic(450, 0, 0);
    wait_quiet();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
